// ===== src/swmb_pkg.sv =====
// ----------------------------------------------------------------------------
// swmb_pkg
// Shared types and constants of the spatial weight matrix builder.
// ----------------------------------------------------------------------------
package swmb_pkg;

  localparam int unsigned MaxSitesDefault = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 48;
  localparam int unsigned SizeW = 7;

  localparam logic [SizeW-1:0] SizeReset = 7'd64;

  typedef enum logic [1:0] {
    REG_CUTOFF    = 2'd0,
    REG_SIZE      = 2'd1,
    REG_INVERSE   = 2'd2,
    REG_NORMALIZE = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_DIV,
    ST_WR_SQRT,
    ST_WR_SUM_RD,
    ST_WR_SUM_WB,
    ST_RD_MEM,
    ST_RD_WAIT,
    ST_RD_DIV,
    ST_RD_OUT,
    ST_CLEAR,
    ST_ROW_FIX
  } state_e;

  typedef struct packed {
    logic wr_start;
    logic div_start;
    logic sqrt_start;
    logic sum_wb;
    logic sum_rd;
    logic rd_latch;
    logic out_load;
    logic clear_step;
    logic fix_start;
  } cmd_t;

  typedef struct packed {
    logic wr_skip;
    logic wr_zero;
    logic div_done;
    logic sqrt_done;
    logic norm_bypass;
    logic clear_done;
    logic out_full;
    logic row_stale;
    logic fix_done;
  } sts_t;

endpackage

// ===== src/swmb_if.sv =====
// ----------------------------------------------------------------------------
// swmb_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface swmb_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/swmb_ram.sv =====
// ----------------------------------------------------------------------------
// swmb_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module swmb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/swmb_datapath.sv =====
// ----------------------------------------------------------------------------
// swmb_datapath
// Counters, row sums, matrix store, and the shared bit-serial divide and
// square root unit.
// ----------------------------------------------------------------------------
module swmb_datapath import swmb_pkg::*; #(
  parameter int unsigned MaxSites = MaxSitesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [DataW-1:0] distance_i,
  input  logic [DataW-1:0] cutoff_i,
  input  logic [SizeW-1:0] size_i,
  input  logic             do_inverse_i,
  input  logic             do_normalize_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [DataW-1:0] weight_o,
  output logic             last_o
);
  localparam int unsigned Depth = MaxSites * MaxSites;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned RowW  = $clog2(MaxSites);
  localparam int unsigned NW    = $clog2(MaxSites + 1);
  localparam int unsigned TotW  = 2 * NW;
  localparam int unsigned ClrW  = $clog2(MaxSites + 1);
  localparam int unsigned FixW  = $clog2(CntW + 1);

  // effective n
  logic [NW-1:0] n_eff;
  always_comb begin
    if (size_i == '0) n_eff = NW'(1);
    else if (32'(size_i) > MaxSites) n_eff = NW'(MaxSites);
    else n_eff = NW'(size_i);
  end
  logic [TotW-1:0] total;
  assign total = TotW'(n_eff) * TotW'(n_eff);

  logic [CntW-1:0] load_cnt_q, load_cnt_d, read_cnt_q, read_cnt_d;
  logic [RowW-1:0] load_row_q, load_row_d, read_row_q, read_row_d;
  logic [ClrW-1:0] clr_q, clr_d;
  logic            last_q, last_d;

  // row index recompute after a size change
  logic [NW-1:0]   n_row_q;
  logic [CntW-1:0] fix_lsh_q, fix_lsh_d, fix_rsh_q, fix_rsh_d;
  logic [NW-1:0]   lrem_q, lrem_d, rrem_q, rrem_d;
  logic [NW:0]     ltry, rtry;
  logic [FixW-1:0] fix_cnt_q, fix_cnt_d;

  // arithmetic unit
  logic [63:0]     num_q, num_d;
  logic [SumW-1:0] den_q, den_d;
  logic [63:0]     rem_q, rem_d;
  logic [63:0]     quo_q, quo_d;
  logic [6:0]      step_q, step_d;
  logic            busy_q, busy_d;
  logic            sq_q, sq_d;
  logic [31:0]     wval_q, wval_d;
  logic [SumW-1:0] cur_sum_q, cur_sum_d;

  logic [DataW-1:0] ram_rdata, ram_wdata;
  logic [AddrW-1:0] ram_addr;
  logic             ram_we;

  logic [SumW-1:0]  sum_rdata, sum_wdata;
  logic [RowW-1:0]  sum_addr;
  logic             sum_we;

  logic [31:0]      tr_val;

  swmb_ram #(.Width(DataW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  swmb_ram #(.Width(SumW), .Depth(MaxSites)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .addr_i  (sum_addr),
    .wdata_i (sum_wdata),
    .rdata_o (sum_rdata)
  );

  assign ram_we    = cmd_i.sum_wb;
  assign ram_wdata = tr_val;
  assign ram_addr  = cmd_i.sum_wb ? AddrW'(load_cnt_q) : AddrW'(read_cnt_q);

  assign sum_we    = cmd_i.sum_wb || cmd_i.clear_step;
  assign sum_addr  = cmd_i.clear_step ? clr_q[RowW-1:0] :
                     ((cmd_i.sum_rd || cmd_i.sum_wb) ? load_row_q : read_row_q);
  assign sum_wdata = cmd_i.clear_step ? '0 : sum_rdata + SumW'(tr_val);

  logic [63:0] trial;
  logic [65:0] sq_trial;
  logic [65:0] sq_rem;

  always_comb begin
    num_d = num_q; den_d = den_q; rem_d = rem_q; quo_d = quo_q;
    step_d = step_q; busy_d = busy_q; sq_d = sq_q; wval_d = wval_q;
    cur_sum_d = cur_sum_q;
    trial = '0; sq_trial = '0; sq_rem = '0;
    if (cmd_i.wr_start) begin
      wval_d = distance_i;
    end
    if (cmd_i.div_start) begin
      busy_d = 1'b1; sq_d = 1'b0; step_d = 7'd0; rem_d = '0; quo_d = '0;
      if (cmd_i.rd_latch) begin
        num_d = {16'd0, wval_q, 16'd0};
        den_d = cur_sum_q;
      end else begin
        num_d = 64'd1 << 48;
        den_d = SumW'(distance_i);
      end
    end else if (cmd_i.sqrt_start) begin
      busy_d = 1'b1; sq_d = 1'b1; step_d = 7'd0; rem_d = '0;
      num_d = quo_q; quo_d = '0;
    end else if (busy_q) begin
      if (!sq_q) begin
        trial = {rem_q[62:0], num_q[63]};
        num_d = {num_q[62:0], 1'b0};
        if (trial >= 64'(den_q)) begin
          rem_d = trial - 64'(den_q); quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = trial; quo_d = {quo_q[62:0], 1'b0};
        end
        step_d = step_q + 7'd1;
        if (step_q == 7'd63) busy_d = 1'b0;
      end else begin
        sq_rem = {rem_q, num_q[63:62]};
        sq_trial = {quo_q, 2'b01};
        num_d = {num_q[61:0], 2'b00};
        if (sq_rem >= sq_trial) begin
          rem_d = 64'(sq_rem - sq_trial); quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = 64'(sq_rem); quo_d = {quo_q[62:0], 1'b0};
        end
        step_d = step_q + 7'd1;
        if (step_q == 7'd31) busy_d = 1'b0;
      end
    end
    if (cmd_i.sum_wb) begin
      wval_d = wval_q;
    end
    if (cmd_i.rd_latch && !cmd_i.div_start) begin
      wval_d = ram_rdata;
      cur_sum_d = sum_rdata;
    end
  end

  // restoring remainder of both counters by n, one bit a cycle
  always_comb begin
    fix_lsh_d = fix_lsh_q; fix_rsh_d = fix_rsh_q;
    lrem_d = lrem_q; rrem_d = rrem_q; fix_cnt_d = fix_cnt_q;
    ltry = {lrem_q, fix_lsh_q[CntW-1]};
    rtry = {rrem_q, fix_rsh_q[CntW-1]};
    if (cmd_i.fix_start) begin
      fix_lsh_d = load_cnt_q; fix_rsh_d = read_cnt_q;
      lrem_d = '0; rrem_d = '0;
      fix_cnt_d = FixW'(CntW);
    end else if (fix_cnt_q != '0) begin
      fix_lsh_d = {fix_lsh_q[CntW-2:0], 1'b0};
      fix_rsh_d = {fix_rsh_q[CntW-2:0], 1'b0};
      lrem_d = (ltry >= {1'b0, n_eff}) ? NW'(ltry - {1'b0, n_eff}) : NW'(ltry);
      rrem_d = (rtry >= {1'b0, n_eff}) ? NW'(rtry - {1'b0, n_eff}) : NW'(rtry);
      fix_cnt_d = fix_cnt_q - FixW'(1);
    end
  end

  // write value selection after transform
  always_comb begin
    if (sts_o.wr_zero) tr_val = '0;
    else if (do_inverse_i) tr_val = quo_q[31:0];
    else tr_val = wval_q;
  end

  // output register
  logic            out_valid_q, out_valid_d;
  logic [DataW-1:0] weight_q, weight_d;
  logic [DataW-1:0] norm_val;
  always_comb begin
    if (sts_o.norm_bypass) norm_val = do_normalize_i ? '0 : wval_q;
    else if (quo_q[63:32] != '0) norm_val = '1;
    else norm_val = quo_q[31:0];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    weight_d = weight_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      weight_d = norm_val;
    end
  end

  always_comb begin
    load_cnt_d = load_cnt_q; load_row_d = load_row_q;
    read_cnt_d = read_cnt_q; read_row_d = read_row_q;
    clr_d = clr_q; last_d = last_q;
    if (cmd_i.sum_wb) begin
      load_cnt_d = load_cnt_q + CntW'(1);
      load_row_d = (32'(load_row_q) + 1 >= 32'(n_eff)) ? '0 : load_row_q + RowW'(1);
    end
    if (cmd_i.out_load) begin
      last_d = (32'(read_cnt_q) + 1 >= 32'(total));
      if (32'(read_cnt_q) + 1 >= 32'(total)) begin
        read_cnt_d = '0; read_row_d = '0; load_cnt_d = '0; load_row_d = '0;
        clr_d = '0;
      end else begin
        read_cnt_d = read_cnt_q + CntW'(1);
        read_row_d = (32'(read_row_q) + 1 >= 32'(n_eff)) ? '0 : read_row_q + RowW'(1);
      end
    end
    if (fix_cnt_q == FixW'(1)) begin
      load_row_d = RowW'(lrem_d);
      read_row_d = RowW'(rrem_d);
    end
    if (cmd_i.clear_step) clr_d = clr_q + ClrW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0; load_row_q <= '0; read_cnt_q <= '0; read_row_q <= '0;
      clr_q <= '0; busy_q <= 1'b0; out_valid_q <= 1'b0;
      last_q <= 1'b0; fix_cnt_q <= '0; n_row_q <= '0;
    end else begin
      load_cnt_q <= load_cnt_d; load_row_q <= load_row_d;
      read_cnt_q <= read_cnt_d; read_row_q <= read_row_d;
      clr_q <= clr_d; busy_q <= busy_d; out_valid_q <= out_valid_d;
      last_q <= last_d; fix_cnt_q <= fix_cnt_d;
      if (cmd_i.fix_start) n_row_q <= n_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d; quo_q <= quo_d;
    step_q <= step_d; sq_q <= sq_d;
    wval_q <= cmd_i.sum_wb ? tr_val : wval_d;
    cur_sum_q <= cur_sum_d; weight_q <= weight_d;
    fix_lsh_q <= fix_lsh_d; fix_rsh_q <= fix_rsh_d;
    lrem_q <= lrem_d; rrem_q <= rrem_d;
  end

  assign sts_o.wr_skip     = 32'(load_cnt_q) >= 32'(total);
  assign sts_o.wr_zero     = do_inverse_i &&
                             ((36'(wval_q) * 36'd10 <= 36'd65536) || (wval_q >= cutoff_i));
  assign sts_o.div_done    = !busy_q;
  assign sts_o.sqrt_done   = !busy_q;
  assign sts_o.norm_bypass = !do_normalize_i || (cur_sum_q == '0);
  assign sts_o.clear_done  = 32'(clr_q) >= MaxSites;
  assign sts_o.out_full    = out_valid_q && !out_ready_i;
  assign sts_o.row_stale   = n_row_q != n_eff;
  assign sts_o.fix_done    = fix_cnt_q == '0;

  assign out_valid_o = out_valid_q;
  assign weight_o    = weight_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(load_cnt_q) <= Depth) else $error("load count out of range");
  a_no_double_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.div_start && cmd_i.sqrt_start)) else $error("two unit starts");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !sts_o.out_full) else $error("output overrun");
`endif
endmodule

// ===== src/swmb_ctrl.sv =====
// ----------------------------------------------------------------------------
// swmb_ctrl
// Sequencer for load and read items, the row sum clearing pass and the row index fix.
// ----------------------------------------------------------------------------
module swmb_ctrl import swmb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_func_i,
  input  logic do_inverse_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) state_d = ST_IDLE;
        else cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        if (!sts_i.clear_done) begin
          state_d = ST_CLEAR;
        end else if (sts_i.row_stale) begin
          cmd_o.fix_start = 1'b1;
          state_d = ST_ROW_FIX;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            if (!in_func_i) begin
              if (!sts_i.wr_skip) begin
                cmd_o.wr_start = 1'b1;
                if (do_inverse_i) begin
                  cmd_o.div_start = 1'b1;
                  state_d = ST_WR_DIV;
                end else begin
                  state_d = ST_WR_SUM_RD;
                end
              end
            end else begin
              state_d = ST_RD_MEM;
            end
          end
        end
      end
      ST_ROW_FIX: if (sts_i.fix_done) state_d = ST_IDLE;
      ST_WR_DIV: if (sts_i.div_done) begin
        cmd_o.sqrt_start = 1'b1;
        state_d = ST_WR_SQRT;
      end
      ST_WR_SQRT: if (sts_i.sqrt_done) state_d = ST_WR_SUM_RD;
      ST_WR_SUM_RD: begin
        cmd_o.sum_rd = 1'b1;
        state_d = ST_WR_SUM_WB;
      end
      ST_WR_SUM_WB: begin
        cmd_o.sum_wb = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RD_MEM: state_d = ST_RD_WAIT;
      ST_RD_WAIT: begin
        cmd_o.rd_latch = 1'b1;
        state_d = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!sts_i.norm_bypass) begin
          cmd_o.div_start = 1'b1;
          cmd_o.rd_latch = 1'b1;
          state_d = ST_RD_DIV;
        end else if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RD_DIV: if (sts_i.div_done && !sts_i.out_full) begin
        cmd_o.out_load = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sum_wb, cmd_o.out_load, cmd_o.clear_step}))
    else $error("conflicting commands");
  a_no_ready_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sts_i.clear_done |-> !in_ready_o) else $error("ready during clear");
`endif
endmodule

// ===== src/spatial_weight_matrix_builder_top.sv =====
// ----------------------------------------------------------------------------
// spatial_weight_matrix_builder_top
// Row-standardized inverse-distance weight matrix builder.
// ----------------------------------------------------------------------------
// Input channel in_if: func 0 loads the next distance (column-major order),
// func 1 requests the next weight. Output channel out_if returns one weight
// per read request, with last set on the final element.
// A load with inverse mode on runs a 64-step bit-serial divide of 2^48
// by d, then a 32-step square root on one shared unit, then a row sum
// read and write back; a load without the transform does only the row sum
// read and write back. With normalization a read has the same unit divide
// the stored weight by the row sum. One item is in work at a time.
// A stalled receiver holds the weight and blocks only the next read result.
// After reset and after the last read a clearing pass over all MaxSites
// row sums zeroes them; no item is taken during it. The first item after a
// size change waits while the row indexes are recomputed.
// Registers on the APB port: cutoff at 0x0, size_in_use at 0x4,
// do_inverse at 0x8, do_normalize at 0xC.
// ----------------------------------------------------------------------------
module spatial_weight_matrix_builder_top import swmb_pkg::*; #(
  parameter int unsigned MaxSites = MaxSitesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swmb_if.sink        in_if,
  swmb_if.source      out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [DataW-1:0] cutoff_q;
  logic [SizeW-1:0] size_q;
  logic             inv_q, norm_q;
  reg_idx_e         ridx;
  logic             wr_en;

  assign ridx   = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= '1; size_q <= SizeReset; inv_q <= 1'b1; norm_q <= 1'b1;
    end else if (wr_en) begin
      case (ridx)
        REG_CUTOFF:    cutoff_q <= pwdata;
        REG_SIZE:      size_q <= pwdata[SizeW-1:0];
        REG_INVERSE:   inv_q <= pwdata[0];
        REG_NORMALIZE: norm_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_CUTOFF:    prdata = cutoff_q;
      REG_SIZE:      prdata = {25'd0, size_q};
      REG_INVERSE:   prdata = {31'd0, inv_q};
      REG_NORMALIZE: prdata = {31'd0, norm_q};
      default:       prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;

  swmb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_func_i    (in_if.data.func),
    .do_inverse_i (inv_q),
    .in_ready_o   (in_if.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  swmb_datapath #(.MaxSites(MaxSites)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .distance_i     (in_if.data.distance),
    .cutoff_i       (cutoff_q),
    .size_i         (size_q),
    .do_inverse_i   (inv_q),
    .do_normalize_i (norm_q),
    .out_ready_i    (out_if.ready),
    .out_valid_o    (out_if.valid),
    .weight_o       (out_if.data.weight),
    .last_o         (out_if.data.last)
  );
endmodule
